[src/vtpg_pkg.sv]
`default_nettype none
package vtpg_pkg;

    // coordinate and size fields
    localparam int EXTENT_BITS = 10;
    localparam int EXT_REG_W   = 3 * EXTENT_BITS;

    // q8.8 spacing and radius fields
    localparam int Q_W       = 16;
    localparam int Q_REG_W   = 3 * Q_W;
    localparam int FRAC_BITS = 8;

    // value widths
    localparam int VAL_W = 32;
    localparam int OUT_W = 40;

    // datapath widths
    localparam int DIFF_W = EXTENT_BITS + 1;
    localparam int A_W    = DIFF_W + Q_W;
    localparam int ASQ_W  = 2 * A_W;
    localparam int B_W    = Q_W + 1;
    localparam int B2_W   = 2 * B_W;
    localparam int K_W    = 2 * B2_W;
    localparam int RHS_W  = K_W + B2_W;
    localparam int TERM_W = ASQ_W + K_W;
    localparam int LHS_W  = TERM_W + 2;
    localparam int DSUM_W = ASQ_W + 2;
    localparam int ROOT_W = (DSUM_W + 1) / 2;

    // pipeline layout
    localparam int SQRT_STAGES    = (ROOT_W + 1) / 2;
    localparam int ELL_STAGES     = 6;
    localparam int STG_SIMPLE     = 4;
    localparam int STG_ELL_FIRST  = 4;
    localparam int STG_ELL_LAST   = STG_ELL_FIRST + ELL_STAGES - 1;
    localparam int STG_SQRT_FIRST = 5;
    localparam int STG_SQRT_LAST  = STG_SQRT_FIRST + SQRT_STAGES - 1;
    localparam int PIPE_DEPTH     = STG_SQRT_LAST + 1;

    // register port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    localparam int CHESS_VALUE = 255;

    // register reset values
    localparam logic [2:0]           MODE_RST    = 3'd0;
    localparam logic [EXT_REG_W-1:0] EXTENT_RST  = EXT_REG_W'(134348928);
    localparam logic [Q_REG_W-1:0]   SPACING_RST = Q_REG_W'(48'd1099528405248);
    localparam logic [Q_REG_W-1:0]   RADII_RST   = Q_REG_W'(48'd21990568104960);
    localparam logic [EXT_REG_W-1:0] STEPS_RST   = EXT_REG_W'(2099202);
    localparam logic [VAL_W-1:0]     FG_RST      = VAL_W'(1);
    localparam logic [VAL_W-1:0]     BG_RST      = VAL_W'(0);

    typedef enum logic [2:0] {
        MODE_CUBOID    = 3'd0,
        MODE_ELLIPSOID = 3'd1,
        MODE_GRID      = 3'd2,
        MODE_CARD      = 3'd3,
        MODE_DISTANCE  = 3'd4,
        MODE_NUMBER    = 3'd5,
        MODE_CHESS     = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_EXTENT  = 3'd1,
        REG_SPACING = 3'd2,
        REG_RADII   = 3'd3,
        REG_STEPS   = 3'd4,
        REG_FG      = 3'd5,
        REG_BG      = 3'd6
    } reg_idx_t;

endpackage
`default_nettype wire

[src/vtpg_sqrt.sv]
`default_nettype none
module vtpg_sqrt
    import vtpg_pkg::*;
(
    input  logic                   clk,
    input  logic [SQRT_STAGES-1:0] stage_en,
    input  logic [DSUM_W-1:0]      radicand,
    output logic [ROOT_W-1:0]      root
);

    localparam int SQ_IW = DSUM_W + 1;

    typedef struct packed {
        logic [SQ_IW-1:0] rem;
        logic [SQ_IW-1:0] res;
    } sq_t;

    // one digit of the restoring square root
    function automatic sq_t sq_iter(input sq_t s, input int j);
        logic [SQ_IW-1:0] bitv;
        logic [SQ_IW-1:0] trial;
        sq_t              o;
        o = s;
        if (j >= 0)
        begin
            bitv  = SQ_IW'(1) << (2 * j);
            trial = s.res + bitv;
            if (s.rem >= trial)
            begin
                o.rem = s.rem - trial;
                o.res = (s.res >> 1) + bitv;
            end
            else
            begin
                o.rem = s.rem;
                o.res = s.res >> 1;
            end
        end
        return o;
    endfunction

    sq_t st_reg [SQRT_STAGES];
    sq_t prev   [SQRT_STAGES];

    // stage inputs
    always_comb
    begin
        prev[0].rem = SQ_IW'(radicand);
        prev[0].res = '0;
        for (int s = 1; s < SQRT_STAGES; s++)
        begin
            prev[s] = st_reg[s-1];
        end
    end

    // two root bits per stage
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            if (stage_en[s])
            begin
                st_reg[s] <= sq_iter(sq_iter(prev[s], ROOT_W - 1 - 2 * s), ROOT_W - 2 - 2 * s);
            end
        end
    end

    assign root = st_reg[SQRT_STAGES-1].res[ROOT_W-1:0];

endmodule
`default_nettype wire

[src/vtpg_ellip.sv]
`default_nettype none
module vtpg_ellip
    import vtpg_pkg::*;
(
    input  logic                      clk,
    input  logic [ELL_STAGES-1:0]     stage_en,
    input  logic [2:0][ASQ_W-1:0]     asq,
    input  logic [2:0][K_W-1:0]       kprod,
    input  logic [RHS_W-1:0]          rhs,
    input  logic                      zero_radius,
    output logic                      in_shape
);

    localparam int PH     = ASQ_W / 2;
    localparam int PW     = ASQ_W - PH + B2_W;
    localparam int LOHI_W = PW + PH + 1;
    localparam int S01_W  = TERM_W + 1;

    logic [PW-1:0]     p_reg  [3][4];
    logic [LOHI_W-1:0] lo_reg [3];
    logic [LOHI_W-1:0] hi_reg [3];
    logic [TERM_W-1:0] term_reg [3];
    logic [S01_W-1:0]  s01_reg;
    logic [TERM_W-1:0] tz_reg;
    logic [LHS_W-1:0]  lhs_reg;
    logic              inside_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            // partial products of a^2 times the other two axes' b^2 product
            if (stage_en[0])
            begin
                p_reg[i][0] <= PW'(asq[i][PH-1:0]) * PW'(kprod[i][B2_W-1:0]);
                p_reg[i][1] <= PW'(asq[i][PH-1:0]) * PW'(kprod[i][K_W-1:B2_W]);
                p_reg[i][2] <= PW'(asq[i][ASQ_W-1:PH]) * PW'(kprod[i][B2_W-1:0]);
                p_reg[i][3] <= PW'(asq[i][ASQ_W-1:PH]) * PW'(kprod[i][K_W-1:B2_W]);
            end
            // fold the a^2 halves
            if (stage_en[1])
            begin
                lo_reg[i] <= LOHI_W'(p_reg[i][0]) + (LOHI_W'(p_reg[i][2]) << PH);
                hi_reg[i] <= LOHI_W'(p_reg[i][1]) + (LOHI_W'(p_reg[i][3]) << PH);
            end
            // fold the k halves
            if (stage_en[2])
            begin
                term_reg[i] <= TERM_W'(lo_reg[i]) + (TERM_W'(hi_reg[i]) << B2_W);
            end
        end
        // sum of the three terms
        if (stage_en[3])
        begin
            s01_reg <= S01_W'(term_reg[0]) + S01_W'(term_reg[1]);
            tz_reg  <= term_reg[2];
        end
        if (stage_en[4])
        begin
            lhs_reg <= LHS_W'(s01_reg) + LHS_W'(tz_reg);
        end
        // exact compare against the product of all b^2
        if (stage_en[5])
        begin
            inside_reg <= !zero_radius && (lhs_reg < LHS_W'(rhs));
        end
    end

    assign in_shape = inside_reg;

endmodule
`default_nettype wire

[src/voxel_test_pattern_generator_core.sv]
`default_nettype none
// Voxel test pattern generator: each coord_x/y/z transfer yields one voxel_value
// (signed Q31.8) for the pattern chosen in the mode register. The pipeline is 19
// register stages deep and takes one voxel every clock; the depth is set by the
// square root of the distance pattern, which resolves two root bits per stage.
// Stages hold their data under out_stall and empty stages fill up, so input keeps
// flowing while a result waits until all stages are full. Products of the radii (for
// the ellipsoid) and of the extents are recomputed continuously from the registers
// and settle before any item that follows can reach them.
// Registers sit on the apb port at byte address 8*index with 64-bit data.
module voxel_test_pattern_generator_core
    import vtpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [EXTENT_BITS-1:0]    coord_x,
    input  logic [EXTENT_BITS-1:0]    coord_y,
    input  logic [EXTENT_BITS-1:0]    coord_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   voxel_value
);

    localparam int EB   = EXTENT_BITS;
    localparam int EB2  = 2 * EB;
    localparam int EB3  = 3 * EB;
    localparam int LO_N = EB / 2;
    localparam int HI_N = EB - LO_N;

    // remainder steps, one dividend bit each
    function automatic logic [EB-1:0] rem_steps(input logic [EB-1:0] rin,
                                                input logic [EB-1:0] bits,
                                                input int            cnt,
                                                input logic [EB-1:0] dv);
        logic [EB:0] r;
        r = {1'b0, rin};
        for (int i = EB - 1; i >= 0; i--)
        begin
            if (i < cnt)
            begin
                r = {r[EB-1:0], bits[i]};
                if (r >= {1'b0, dv})
                begin
                    r = r - {1'b0, dv};
                end
            end
        end
        return r[EB-1:0];
    endfunction

    // doubled offset from the volume centre
    function automatic logic [DIFF_W-1:0] off2(input logic [EB-1:0] c, input logic [EB-1:0] m);
        logic [DIFF_W-1:0] t;
        logic [DIFF_W-1:0] mm;
        t  = {c, 1'b0};
        mm = DIFF_W'(m);
        return (t >= mm) ? (t - mm) : (mm - t);
    endfunction

    // configuration registers
    logic [2:0]           mode_reg;
    logic [EXT_REG_W-1:0] extent_reg;
    logic [Q_REG_W-1:0]   spacing_reg;
    logic [Q_REG_W-1:0]   radii_reg;
    logic [EXT_REG_W-1:0] steps_reg;
    logic [VAL_W-1:0]     fg_reg;
    logic [VAL_W-1:0]     bg_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RST;
            extent_reg  <= EXTENT_RST;
            spacing_reg <= SPACING_RST;
            radii_reg   <= RADII_RST;
            steps_reg   <= STEPS_RST;
            fg_reg      <= FG_RST;
            bg_reg      <= BG_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MODE:    mode_reg    <= pwdata[2:0];
                REG_EXTENT:  extent_reg  <= pwdata[EXT_REG_W-1:0];
                REG_SPACING: spacing_reg <= pwdata[Q_REG_W-1:0];
                REG_RADII:   radii_reg   <= pwdata[Q_REG_W-1:0];
                REG_STEPS:   steps_reg   <= pwdata[EXT_REG_W-1:0];
                REG_FG:      fg_reg      <= pwdata[VAL_W-1:0];
                REG_BG:      bg_reg      <= pwdata[VAL_W-1:0];
                default:     ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx)
            REG_MODE:    prdata = PDATA_W'(mode_reg);
            REG_EXTENT:  prdata = PDATA_W'(extent_reg);
            REG_SPACING: prdata = PDATA_W'(spacing_reg);
            REG_RADII:   prdata = PDATA_W'(radii_reg);
            REG_STEPS:   prdata = PDATA_W'(steps_reg);
            REG_FG:      prdata = PDATA_W'(fg_reg);
            REG_BG:      prdata = PDATA_W'(bg_reg);
            default:     prdata = '0;
        endcase
    end

    // unpacked configuration fields
    logic [EB-1:0]  n_cfg  [3];
    logic [EB-1:0]  m_cfg  [3];
    logic [EB-1:0]  st_cfg [3];
    logic [Q_W-1:0] sp_cfg [3];
    logic [B_W-1:0] b_cfg  [3];
    logic           zero_radius;
    logic [OUT_W-1:0] fg40;
    logic [OUT_W-1:0] bg40;

    always_comb
    begin
        zero_radius = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            n_cfg[i]  = (extent_reg[i*EB +: EB] == '0) ? EB'(1) : extent_reg[i*EB +: EB];
            m_cfg[i]  = n_cfg[i] - EB'(1);
            st_cfg[i] = (steps_reg[i*EB +: EB] == '0) ? EB'(1) : steps_reg[i*EB +: EB];
            sp_cfg[i] = spacing_reg[i*Q_W +: Q_W];
            b_cfg[i]  = {radii_reg[i*Q_W +: Q_W], 1'b0};
            if (radii_reg[i*Q_W +: Q_W] == '0)
            begin
                zero_radius = 1'b1;
            end
        end
        fg40 = {{(OUT_W-VAL_W-FRAC_BITS){fg_reg[VAL_W-1]}}, fg_reg, {FRAC_BITS{1'b0}}};
        bg40 = {{(OUT_W-VAL_W-FRAC_BITS){bg_reg[VAL_W-1]}}, bg_reg, {FRAC_BITS{1'b0}}};
    end

    // products of configuration, refreshed every clock
    logic [B2_W-1:0]      b2_reg [3];
    logic [2:0][K_W-1:0]  k_reg;
    logic [K_W-1:0]       rp_lo_reg;
    logic [K_W-1:0]       rp_hi_reg;
    logic [RHS_W-1:0]     rhs_reg;
    logic [EB2-1:0]       nxy_reg;
    logic [EB3-1:0]       ntot_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            b2_reg[i] <= B2_W'(b_cfg[i]) * B2_W'(b_cfg[i]);
        end
        k_reg[0]  <= K_W'(b2_reg[1]) * K_W'(b2_reg[2]);
        k_reg[1]  <= K_W'(b2_reg[0]) * K_W'(b2_reg[2]);
        k_reg[2]  <= K_W'(b2_reg[0]) * K_W'(b2_reg[1]);
        rp_lo_reg <= K_W'(k_reg[2][B2_W-1:0]) * K_W'(b2_reg[2]);
        rp_hi_reg <= K_W'(k_reg[2][K_W-1:B2_W]) * K_W'(b2_reg[2]);
        rhs_reg   <= RHS_W'(rp_lo_reg) + (RHS_W'(rp_hi_reg) << B2_W);
        nxy_reg   <= EB2'(n_cfg[0]) * EB2'(n_cfg[1]);
        ntot_reg  <= EB3'(nxy_reg) * EB3'(n_cfg[2]);
    end

    // stage enables: a stage loads when empty or when its successor moves
    logic [PIPE_DEPTH:1] v_reg;
    logic [PIPE_DEPTH:1] en;

    always_comb
    begin
        en[PIPE_DEPTH] = !v_reg[PIPE_DEPTH] || !out_stall;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[1];
    assign out_valid = v_reg[PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= PIPE_DEPTH; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // datapath registers
    logic [EB-1:0]      cin      [3];
    logic [EB-1:0]      c1_reg   [3];
    logic [DIFF_W-1:0]  d1_reg   [3];
    logic [EB-1:0]      c2_reg   [3];
    logic [A_W-1:0]     a2_reg   [3];
    logic [EB-1:0]      rem2_reg [3];
    logic [EB2-1:0]     cxy2_reg;
    logic [EB2-1:0]     zy2_reg;
    logic               outer2_reg;
    logic               shell2_reg;
    logic               chess2_reg;
    logic [2:0][ASQ_W-1:0] asq3_reg;
    logic               box3_reg;
    logic               grid3_reg;
    logic [EB3-1:0]     cxyz3_reg;
    logic [EB3-1:0]     lin3_reg;
    logic               outer3_reg;
    logic               shell3_reg;
    logic               chess3_reg;
    logic [DSUM_W-1:0]  dsum4_reg;
    logic [OUT_W-1:0]   sv_reg  [STG_SIMPLE:STG_SQRT_LAST];
    logic               ell_reg [STG_ELL_LAST+1:STG_SQRT_LAST];
    logic [OUT_W-1:0]   out_reg;

    logic               outer_next;
    logic               shell_next;
    logic               box_next;
    logic               grid_next;
    logic [OUT_W-1:0]   sv_next;
    logic               ell_inside;
    logic [ROOT_W-1:0]  root;
    logic [ROOT_W:0]    dist_round;
    logic [OUT_W-1:0]   out_next;

    assign cin[0] = coord_x;
    assign cin[1] = coord_y;
    assign cin[2] = coord_z;

    // border, shell, box and grid flags
    always_comb
    begin
        outer_next = 1'b0;
        shell_next = 1'b0;
        box_next   = !zero_radius;
        grid_next  = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (c1_reg[i] == '0 || c1_reg[i] == m_cfg[i])
            begin
                outer_next = 1'b1;
            end
            if (c1_reg[i] == EB'(1) ||
                (n_cfg[i] >= EB'(2) && c1_reg[i] == n_cfg[i] - EB'(2)))
            begin
                shell_next = 1'b1;
            end
            if (!(a2_reg[i] < A_W'(b_cfg[i])))
            begin
                box_next = 1'b0;
            end
            if (rem_steps(rem2_reg[i], EB'(c2_reg[i][LO_N-1:0]), LO_N, st_cfg[i]) != '0)
            begin
                grid_next = 1'b0;
            end
        end
    end

    // value of the patterns that finish early
    always_comb
    begin
        case (mode_t'(mode_reg))
            MODE_CUBOID: sv_next = box3_reg ? fg40 : bg40;
            MODE_GRID:   sv_next = grid3_reg ? fg40 : bg40;
            MODE_CARD:
            begin
                if (outer3_reg)
                begin
                    sv_next = OUT_W'({ntot_reg, {FRAC_BITS{1'b0}}});
                end
                else if (shell3_reg)
                begin
                    sv_next = bg40;
                end
                else
                begin
                    sv_next = OUT_W'({cxyz3_reg, {FRAC_BITS{1'b0}}});
                end
            end
            MODE_NUMBER: sv_next = OUT_W'({lin3_reg, {FRAC_BITS{1'b0}}});
            MODE_CHESS:  sv_next = chess3_reg ? OUT_W'(CHESS_VALUE << FRAC_BITS) : bg40;
            default:     sv_next = bg40;
        endcase
    end

    // final selection
    always_comb
    begin
        dist_round = ({1'b0, root} + (ROOT_W+1)'(1)) >> 1;
        case (mode_t'(mode_reg))
            MODE_ELLIPSOID: out_next = ell_reg[STG_SQRT_LAST] ? fg40 : bg40;
            MODE_DISTANCE:  out_next = OUT_W'(dist_round);
            default:        out_next = sv_reg[STG_SQRT_LAST];
        endcase
    end

    always_ff @(posedge clk)
    begin
        // stage 1: coordinates and centre offsets
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                c1_reg[i] <= cin[i];
                d1_reg[i] <= off2(cin[i], m_cfg[i]);
            end
        end
        // stage 2: spacing scale, first remainder half, first products
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                c2_reg[i]   <= c1_reg[i];
                a2_reg[i]   <= A_W'(d1_reg[i]) * A_W'(sp_cfg[i]);
                rem2_reg[i] <= rem_steps('0, EB'(c1_reg[i][EB-1:LO_N]), HI_N, st_cfg[i]);
            end
            cxy2_reg   <= EB2'(c1_reg[0]) * EB2'(c1_reg[1]);
            zy2_reg    <= EB2'(c1_reg[2]) * EB2'(n_cfg[1]) + EB2'(c1_reg[1]);
            outer2_reg <= outer_next;
            shell2_reg <= shell_next;
            chess2_reg <= (c1_reg[0][0] == c1_reg[1][0]);
        end
        // stage 3: squares, box test, grid test, last products
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                asq3_reg[i] <= ASQ_W'(a2_reg[i]) * ASQ_W'(a2_reg[i]);
            end
            box3_reg   <= box_next;
            grid3_reg  <= grid_next;
            cxyz3_reg  <= EB3'(cxy2_reg) * EB3'(c2_reg[2]);
            lin3_reg   <= EB3'(zy2_reg) * EB3'(n_cfg[0]) + EB3'(c2_reg[0]);
            outer3_reg <= outer2_reg;
            shell3_reg <= shell2_reg;
            chess3_reg <= chess2_reg;
        end
        // stage 4: early pattern value, squared distance
        if (en[STG_SIMPLE])
        begin
            sv_reg[STG_SIMPLE] <= sv_next;
            dsum4_reg <= DSUM_W'(asq3_reg[0]) + DSUM_W'(asq3_reg[1]) + DSUM_W'(asq3_reg[2]);
        end
        // delay lines to the output stage
        for (int k = STG_SIMPLE + 1; k <= STG_SQRT_LAST; k++)
        begin
            if (en[k])
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end
        if (en[STG_ELL_LAST+1])
        begin
            ell_reg[STG_ELL_LAST+1] <= ell_inside;
        end
        for (int k = STG_ELL_LAST + 2; k <= STG_SQRT_LAST; k++)
        begin
            if (en[k])
            begin
                ell_reg[k] <= ell_reg[k-1];
            end
        end
        // output register
        if (en[PIPE_DEPTH])
        begin
            out_reg <= out_next;
        end
    end

    assign voxel_value = out_reg;

    vtpg_ellip u_ellip (
        .clk         (clk),
        .stage_en    (en[STG_ELL_LAST:STG_ELL_FIRST]),
        .asq         (asq3_reg),
        .kprod       (k_reg),
        .rhs         (rhs_reg),
        .zero_radius (zero_radius),
        .in_shape    (ell_inside)
    );

    vtpg_sqrt u_sqrt (
        .clk      (clk),
        .stage_en (en[STG_SQRT_LAST:STG_SQRT_FIRST]),
        .radicand (dsum4_reg),
        .root     (root)
    );

`ifndef ASSERT_OFF
    // input only backs up when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> (&v_reg))
        else $error("input stalled with an empty stage");

    // an accepted transfer lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[1])
        else $error("accepted transfer lost at stage one");

    // a draining output frees the whole pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |-> !in_stall)
        else $error("input stalled while output drains");
`endif

endmodule
`default_nettype wire
